[sv/mccs_pkg.sv]
`default_nettype none

package mccs_pkg;

  // default sizes
  localparam int MAX_AMOUNT_DEF = 4095;
  localparam int MAX_DENOMS_DEF = 16;

  // field widths
  localparam int VAL_W = 12;
  localparam int OP_W  = 2;

  // stream word widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  // opcodes carried on in_tuser
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_SOLVE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

endpackage

`default_nettype wire

[sv/mccs_amt_ram.sv]
`default_nettype none

module mccs_amt_ram #(
  parameter int DEPTH = mccs_pkg::MAX_AMOUNT_DEF + 1,
  parameter int DW    = 1 + mccs_pkg::VAL_W + 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire            clk,
  input  wire            we,
  input  wire [AW-1:0]   waddr,
  input  wire [DW-1:0]   wdata,
  input  wire [AW-1:0]   raddr,
  output logic [DW-1:0]  rdata_r
);

  logic [DW-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/min_coin_change_solver_core.sv]
`default_nettype none
// append and clear words are handled while idle; the block then takes the next word
// solve: the work for n loaded coins is set by the amount table port: one table read
// per coin per amount, one write per amount
// one word is processed at a time; in_tready is high only while idle with no result pending
// reset (rst_n low, synchronous) empties the coin list and drops any pending result;
// the amount table needs no clearing pass since a solve writes each entry before reading it
module min_coin_change_solver_core #(
  parameter int MAX_AMOUNT = mccs_pkg::MAX_AMOUNT_DEF,
  parameter int MAX_DENOMS = mccs_pkg::MAX_DENOMS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // operand_value [11:0], zero [15:12]
  input  wire [mccs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // opcode [1:0]
  input  wire [mccs_pkg::OP_W-1:0]           in_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // possible [0], total_coins [12:1], denomination [24:13], uses [36:25], zero [39:37]
  output logic [mccs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // is_header [0]
  output logic                               out_tuser,
  output logic                               out_tlast
);

  localparam int VW  = mccs_pkg::VAL_W;
  localparam int AW  = $clog2(MAX_AMOUNT + 1);
  localparam int IW  = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
  localparam int CW  = $clog2(MAX_DENOMS + 1);
  localparam int EW  = 1 + VW + IW;
  localparam int PAD = mccs_pkg::OUT_TDATA_W - (1 + 3 * VW);

  typedef struct packed {
    logic          reach;
    logic [VW-1:0] cnt;
    logic [IW-1:0] pick;
  } entry_t;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_UCLR  = 12'b0000_0000_0010,
    S_INIT  = 12'b0000_0000_0100,
    S_FILL  = 12'b0000_0000_1000,
    S_TGT   = 12'b0000_0001_0000,
    S_TQ    = 12'b0000_0010_0000,
    S_TRD   = 12'b0000_0100_0000,
    S_TPK   = 12'b0000_1000_0000,
    S_TUP   = 12'b0001_0000_0000,
    S_OHDR  = 12'b0010_0000_0000,
    S_OWAIT = 12'b0100_0000_0000,
    S_OLD   = 12'b1000_0000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] tgt_r, tgt_nxt;
  logic [VW-1:0] amt_r, amt_nxt;
  logic [VW-1:0] x_r, x_nxt;
  logic          ok_r, ok_nxt;
  logic [VW-1:0] tot_r, tot_nxt;
  logic [CW-1:0] ji_r, ji_nxt;
  logic          s1_v_r, s1_v_nxt;
  logic [IW-1:0] s1_j_r, s1_j_nxt;
  logic          s2_v_r, s2_v_nxt;
  logic          s2_hit_r, s2_hit_nxt;
  logic [IW-1:0] s2_j_r, s2_j_nxt;
  entry_t        cur_r, cur_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [IW-1:0] p_r, p_nxt;

  logic          out_v_r, out_v_nxt;
  logic          out_hdr_r, out_hdr_nxt;
  logic          out_pos_r, out_pos_nxt;
  logic [VW-1:0] out_tot_r, out_tot_nxt;
  logic [VW-1:0] out_den_r, out_den_nxt;
  logic [VW-1:0] out_use_r, out_use_nxt;
  logic          out_last_r, out_last_nxt;

  // coin list memory
  logic [VW-1:0] den_mem [MAX_DENOMS];
  logic [VW-1:0] den_q_r;
  logic          den_we;
  logic [IW-1:0] den_raddr;

  // per-coin use counters
  logic [VW-1:0] use_mem [MAX_DENOMS];
  logic [VW-1:0] use_q_r;
  logic          use_we;
  logic [IW-1:0] use_waddr;
  logic [VW-1:0] use_wdata;
  logic [IW-1:0] use_raddr;

  // amount table port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_q;

  logic                    in_acc;
  logic                    out_acc;
  logic [mccs_pkg::OP_W-1:0] op;
  logic [VW-1:0]           val;
  logic                    hit;
  logic                    rel_ok;
  logic [VW-1:0]           cand;
  entry_t                  cur_upd;
  logic                    fill_end;

  mccs_amt_ram #(
    .DEPTH (MAX_AMOUNT + 1),
    .DW    (EW)
  ) u_amt_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_v_r && out_tready;
  assign op         = in_tuser;
  assign val        = in_tdata[VW-1:0];

  // relaxation of the current amount against the word read back from the table
  assign hit      = (den_q_r <= amt_r);
  assign rel_ok   = s2_v_r && s2_hit_r && ram_q.reach;
  assign cand     = ram_q.cnt + 1'b1;
  assign fill_end = (ji_r == cnt_r) && !s1_v_r;

  always_comb begin
    cur_upd = cur_r;
    if (rel_ok && (!cur_r.reach || (cand < cur_r.cnt))) begin
      cur_upd.reach = 1'b1;
      cur_upd.cnt   = cand;
      cur_upd.pick  = s2_j_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    tgt_nxt      = tgt_r;
    amt_nxt      = amt_r;
    x_nxt        = x_r;
    ok_nxt       = ok_r;
    tot_nxt      = tot_r;
    ji_nxt       = ji_r;
    s1_v_nxt     = 1'b0;
    s1_j_nxt     = s1_j_r;
    s2_v_nxt     = 1'b0;
    s2_hit_nxt   = s2_hit_r;
    s2_j_nxt     = s2_j_r;
    cur_nxt      = cur_r;
    j_nxt        = j_r;
    p_nxt        = p_r;
    out_v_nxt    = out_v_r;
    out_hdr_nxt  = out_hdr_r;
    out_pos_nxt  = out_pos_r;
    out_tot_nxt  = out_tot_r;
    out_den_nxt  = out_den_r;
    out_use_nxt  = out_use_r;
    out_last_nxt = out_last_r;
    den_we       = 1'b0;
    den_raddr    = j_r[IW-1:0];
    use_we       = 1'b0;
    use_waddr    = j_r[IW-1:0];
    use_wdata    = '0;
    use_raddr    = j_r[IW-1:0];
    ram_we       = 1'b0;
    ram_waddr    = AW'(amt_r);
    ram_wdata    = cur_upd;
    ram_raddr    = AW'(x_r);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op)
            mccs_pkg::OP_APPEND: begin
              if ((val != '0) && (32'(cnt_r) < MAX_DENOMS)) begin
                den_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            mccs_pkg::OP_SOLVE: begin
              tgt_nxt   = val;
              j_nxt     = '0;
              state_nxt = S_UCLR;
            end
            mccs_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // zero the use counters of the loaded coins
      S_UCLR: begin
        if (j_r == cnt_r) begin
          j_nxt = '0;
          if (32'(tgt_r) > MAX_AMOUNT) begin
            ok_nxt    = 1'b0;
            tot_nxt   = '0;
            state_nxt = S_OHDR;
          end else begin
            state_nxt = S_INIT;
          end
        end else begin
          use_we    = 1'b1;
          use_waddr = j_r[IW-1:0];
          use_wdata = '0;
          j_nxt     = j_r + 1'b1;
        end
      end

      // amount zero is reachable with no coins
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{reach: 1'b1, cnt: '0, pick: '0};
        amt_nxt   = VW'(1);
        cur_nxt   = '0;
        ji_nxt    = '0;
        state_nxt = (tgt_r == '0) ? S_TGT : S_FILL;
      end

      // coin read -> table read -> compare, streamed over the coin list
      S_FILL: begin
        if (ji_r != cnt_r) begin
          den_raddr = ji_r[IW-1:0];
          s1_v_nxt  = 1'b1;
          s1_j_nxt  = ji_r[IW-1:0];
          ji_nxt    = ji_r + 1'b1;
        end
        ram_raddr  = AW'(amt_r - den_q_r);
        s2_v_nxt   = s1_v_r;
        s2_hit_nxt = hit;
        s2_j_nxt   = s1_j_r;
        cur_nxt    = cur_upd;
        if (fill_end) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(amt_r);
          ram_wdata = cur_upd;
          cur_nxt   = '0;
          ji_nxt    = '0;
          amt_nxt   = amt_r + 1'b1;
          if (amt_r == tgt_r) begin
            state_nxt = S_TGT;
          end
        end
      end

      S_TGT: begin
        ram_raddr = AW'(tgt_r);
        state_nxt = S_TQ;
      end

      S_TQ: begin
        ok_nxt    = ram_q.reach;
        tot_nxt   = ram_q.reach ? ram_q.cnt : '0;
        x_nxt     = tgt_r;
        state_nxt = ram_q.reach ? S_TRD : S_OHDR;
      end

      // walk the picks back from the target
      S_TRD: begin
        ram_raddr = AW'(x_r);
        state_nxt = (x_r == '0) ? S_OHDR : S_TPK;
      end

      S_TPK: begin
        if (CW'(ram_q.pick) >= cnt_r) begin
          state_nxt = S_OHDR;
        end else begin
          den_raddr = ram_q.pick;
          use_raddr = ram_q.pick;
          p_nxt     = ram_q.pick;
          state_nxt = S_TUP;
        end
      end

      S_TUP: begin
        use_we    = 1'b1;
        use_waddr = p_r;
        use_wdata = use_q_r + 1'b1;
        x_nxt     = x_r - den_q_r;
        state_nxt = S_TRD;
      end

      S_OHDR: begin
        out_v_nxt    = 1'b1;
        out_hdr_nxt  = 1'b1;
        out_pos_nxt  = ok_r;
        out_tot_nxt  = tot_r;
        out_den_nxt  = '0;
        out_use_nxt  = '0;
        out_last_nxt = (cnt_r == '0);
        j_nxt        = '0;
        state_nxt    = S_OWAIT;
      end

      S_OWAIT: begin
        den_raddr = j_r[IW-1:0];
        use_raddr = j_r[IW-1:0];
        if (out_acc) begin
          out_v_nxt = 1'b0;
          state_nxt = out_last_r ? S_IDLE : S_OLD;
        end
      end

      S_OLD: begin
        out_v_nxt    = 1'b1;
        out_hdr_nxt  = 1'b0;
        out_pos_nxt  = 1'b0;
        out_tot_nxt  = '0;
        out_den_nxt  = den_q_r;
        out_use_nxt  = use_q_r;
        out_last_nxt = (CW'(j_r + 1'b1) == cnt_r);
        j_nxt        = j_r + 1'b1;
        state_nxt    = S_OWAIT;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    amt_r      <= amt_nxt;
    x_r        <= x_nxt;
    ok_r       <= ok_nxt;
    tot_r      <= tot_nxt;
    ji_r       <= ji_nxt;
    s1_j_r     <= s1_j_nxt;
    s2_hit_r   <= s2_hit_nxt;
    s2_j_r     <= s2_j_nxt;
    cur_r      <= cur_nxt;
    j_r        <= j_nxt;
    p_r        <= p_nxt;
    out_hdr_r  <= out_hdr_nxt;
    out_pos_r  <= out_pos_nxt;
    out_tot_r  <= out_tot_nxt;
    out_den_r  <= out_den_nxt;
    out_use_r  <= out_use_nxt;
    out_last_r <= out_last_nxt;
  end

  // coin list memory
  always_ff @(posedge clk) begin
    if (den_we) begin
      den_mem[cnt_r[IW-1:0]] <= val;
    end
    den_q_r <= den_mem[den_raddr];
  end

  // use counter memory
  always_ff @(posedge clk) begin
    if (use_we) begin
      use_mem[use_waddr] <= use_wdata;
    end
    use_q_r <= use_mem[use_raddr];
  end

  // result word
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{PAD{1'b0}}, out_use_r, out_den_r, out_tot_r, out_pos_r};
  assign out_tuser  = out_hdr_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while a result is pending");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MAX_DENOMS)
    else $error("coin list count beyond capacity");

  a_trace_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TUP) |-> (den_q_r <= x_r))
    else $error("trace step coin larger than remaining amount");

  a_fill_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FILL) && fill_end) |=> (!s1_v_r && !s2_v_r && (ji_r == '0)))
    else $error("fill pipeline not empty at amount change");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_HALF    = 4;
  localparam int VAL_W       = mccs_pkg::VAL_W;
  localparam int OP_W        = mccs_pkg::OP_W;
  localparam int IN_TDATA_W  = mccs_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = mccs_pkg::OUT_TDATA_W;
  localparam int AMOUNT_TOP  = mccs_pkg::MAX_AMOUNT_DEF;
  localparam int COIN_SLOTS  = mccs_pkg::MAX_DENOMS_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one input word as queued for the driver
  typedef struct {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    bit               drain;
  } stim_word_t;

  // one expected result word
  typedef struct {
    bit               is_header;
    bit               possible;
    logic [VAL_W-1:0] total_coins;
    logic [VAL_W-1:0] denomination;
    logic [VAL_W-1:0] uses;
    bit               last;
  } change_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  stim_word_t   pending_words[$];
  change_word_t change_answers[$];
  int           err_cnt = 0;
  int           words_sent = 0;
  int           queued_cnt = 0;
  bit           steady;

  // predictor state: coin list and the amount tables
  logic [VAL_W-1:0] coin_list[COIN_SLOTS];
  int               coin_cnt = 0;
  int               min_coins[AMOUNT_TOP+1];
  int               pick_of[AMOUNT_TOP+1];
  bit               makeable[AMOUNT_TOP+1];

  min_coin_change_solver_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // no idling on either side for a stretch of words
  assign steady = (words_sent >= 40) && (words_sent < 70);

  task automatic flag_mismatch(input string what, input longint got_val,
                               input longint exp_val);
    $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got_val, exp_val,
             $realtime);
    err_cnt++;
  endtask

  // minimum coin table, earliest coin wins a tie, then trace the picks
  task automatic solve_min_coins(input logic [VAL_W-1:0] target);
    int           uses_of[COIN_SLOTS];
    int           a;
    int           j;
    int           cand;
    int           x;
    int           p;
    bit           ok;
    change_word_t w;
    foreach (uses_of[i]) uses_of[i] = 0;
    min_coins[0] = 0;
    makeable[0] = 1'b1;
    pick_of[0] = 0;
    for (a = 1; a <= int'(target); a++) begin
      makeable[a] = 1'b0;
      min_coins[a] = 0;
      pick_of[a] = 0;
      for (j = 0; j < coin_cnt; j++) begin
        if (int'(coin_list[j]) <= a && makeable[a - int'(coin_list[j])]) begin
          cand = min_coins[a - int'(coin_list[j])] + 1;
          if (!makeable[a] || cand < min_coins[a]) begin
            makeable[a] = 1'b1;
            min_coins[a] = cand;
            pick_of[a] = j;
          end
        end
      end
    end
    ok = makeable[target];
    if (ok) begin
      x = int'(target);
      while (x > 0) begin
        p = pick_of[x];
        if (p >= coin_cnt) break;
        uses_of[p]++;
        x -= int'(coin_list[p]);
      end
    end
    // header word
    w.is_header = 1'b1;
    w.possible = ok;
    w.total_coins = ok ? VAL_W'(min_coins[target]) : '0;
    w.denomination = '0;
    w.uses = '0;
    w.last = (coin_cnt == 0);
    change_answers.push_back(w);
    // one count word per loaded coin
    for (j = 0; j < coin_cnt; j++) begin
      w.is_header = 1'b0;
      w.possible = 1'b0;
      w.total_coins = '0;
      w.denomination = coin_list[j];
      w.uses = VAL_W'(uses_of[j]);
      w.last = (j + 1 == coin_cnt);
      change_answers.push_back(w);
    end
  endtask

  task automatic predict_word(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
    case (op)
      mccs_pkg::OP_APPEND: begin
        if (value != 0 && coin_cnt < COIN_SLOTS) begin
          coin_list[coin_cnt] = value;
          coin_cnt++;
        end
      end
      mccs_pkg::OP_CLEAR: coin_cnt = 0;
      mccs_pkg::OP_SOLVE: solve_min_coins(value);
      default: ;
    endcase
  endtask

  task automatic queue_word(input logic [OP_W-1:0] op, input int value, input bit drain);
    stim_word_t s;
    s.op = op;
    s.value = VAL_W'(value);
    s.drain = drain;
    pending_words.push_back(s);
    if (op != OP_UNUSED && !(op == mccs_pkg::OP_APPEND && value == 0)) queued_cnt++;
  endtask

  // driver: one word in flight, random gaps, optional drain before a word
  always @(posedge clk) begin
    stim_word_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s = pending_words.pop_front();
        predict_word(s.op, s.value);
        words_sent++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (pending_words.size() != 0 &&
            !(pending_words[0].drain && change_answers.size() != 0) &&
            (steady || $urandom_range(0, 99) >= 14)) begin
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_TDATA_W-VAL_W){1'b0}}, pending_words[0].value};
          in_tuser <= pending_words[0].op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    change_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (change_answers.size() == 0) begin
        flag_mismatch("unexpected word", longint'(out_tdata), longint'(0));
      end else begin
        e = change_answers.pop_front();
        if (out_tuser !== e.is_header)
          flag_mismatch("is_header", longint'(out_tuser), longint'(e.is_header));
        if (out_tdata[0] !== e.possible)
          flag_mismatch("possible", longint'(out_tdata[0]), longint'(e.possible));
        if (out_tdata[12:1] !== e.total_coins)
          flag_mismatch("total_coins", longint'(out_tdata[12:1]),
                        longint'(e.total_coins));
        if (out_tdata[24:13] !== e.denomination)
          flag_mismatch("denomination", longint'(out_tdata[24:13]),
                        longint'(e.denomination));
        if (out_tdata[36:25] !== e.uses)
          flag_mismatch("uses", longint'(out_tdata[36:25]), longint'(e.uses));
        if (out_tdata[39:37] !== 3'b000)
          flag_mismatch("pad bits", longint'(out_tdata[39:37]), longint'(0));
        if (out_tlast !== e.last)
          flag_mismatch("last", longint'(out_tlast), longint'(e.last));
      end
    end
    out_tready <= rst_n && (steady || $urandom_range(0, 99) >= 14);
  end

  // stimulus, reset and end of run
  initial begin
    int n_app;
    int n_sol;
    int op;
    int v;
    bit drain;
    // directed: empty list, ignored words, extremes, repeats
    queue_word(mccs_pkg::OP_SOLVE, 0, 1'b0);
    queue_word(mccs_pkg::OP_SOLVE, 7, 1'b0);
    queue_word(mccs_pkg::OP_APPEND, 0, 1'b0);
    queue_word(OP_UNUSED, 12'hfff, 1'b0);
    queue_word(mccs_pkg::OP_APPEND, 1, 1'b0);
    queue_word(mccs_pkg::OP_APPEND, 5, 1'b0);
    queue_word(mccs_pkg::OP_APPEND, 5, 1'b0);
    queue_word(mccs_pkg::OP_APPEND, 12, 1'b0);
    queue_word(mccs_pkg::OP_APPEND, 4095, 1'b0);
    queue_word(mccs_pkg::OP_SOLVE, 4095, 1'b0);
    queue_word(mccs_pkg::OP_SOLVE, 4094, 1'b0);
    queue_word(mccs_pkg::OP_SOLVE, 0, 1'b0);
    queue_word(mccs_pkg::OP_SOLVE, 23, 1'b0);
    queue_word(mccs_pkg::OP_CLEAR, 12'hfff, 1'b0);
    queue_word(mccs_pkg::OP_SOLVE, 7, 1'b0);
    queue_word(mccs_pkg::OP_APPEND, 3, 1'b0);
    queue_word(mccs_pkg::OP_APPEND, 4, 1'b0);
    queue_word(mccs_pkg::OP_SOLVE, 7, 1'b0);
    queue_word(mccs_pkg::OP_SOLVE, 5, 1'b0);
    // full list plus one more append, after all results have drained
    queue_word(mccs_pkg::OP_CLEAR, 0, 1'b1);
    for (int i = 0; i < COIN_SLOTS + 1; i++)
      queue_word(mccs_pkg::OP_APPEND, $urandom_range(1, 60), 1'b0);
    queue_word(mccs_pkg::OP_SOLVE, $urandom_range(100, 250), 1'b0);
    queue_word(mccs_pkg::OP_SOLVE, 0, 1'b0);
    // random: mostly load-and-solve sequences, some noise
    while (queued_cnt < 100) begin
      if ($urandom_range(0, 99) < 80) begin
        drain = ($urandom_range(0, 14) == 0);
        if ($urandom_range(0, 3) != 0)
          queue_word(mccs_pkg::OP_CLEAR, $urandom_range(0, 4095), drain);
        n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
        for (int i = 0; i < n_app; i++) begin
          v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 40);
          queue_word(mccs_pkg::OP_APPEND, v, 1'b0);
        end
        n_sol = $urandom_range(1, 3);
        for (int i = 0; i < n_sol; i++) begin
          v = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 300);
          queue_word(mccs_pkg::OP_SOLVE, v, 1'b0);
        end
      end else begin
        op = $urandom_range(0, 3);
        v = (op == mccs_pkg::OP_SOLVE) ? $urandom_range(0, 300) : $urandom_range(0, 4095);
        queue_word(op[OP_W-1:0], v, 1'b0);
      end
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pending_words.size() != 0 || in_tvalid || change_answers.size() != 0);
    repeat (60) @(posedge clk);
    if (err_cnt == 0 && change_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[min_coin_change_solver_core.f]
sv/mccs_pkg.sv
sv/mccs_amt_ram.sv
sv/min_coin_change_solver_core.sv
tb/sv/tb_top.sv
